// ===== design/msbp_pkg.sv =====
// Shared constants and types for the MSB-first bit packer.
package msbp_pkg;

	localparam int unsigned BYTE_BITS       = 8;
	localparam int unsigned VALUE_BITS      = 32;
	localparam int unsigned MAX_FIELD_WIDTH = 32;
	localparam int unsigned MAX_BYTES       = 4;
	localparam int unsigned WIDTH_BITS      = 6;
	localparam int unsigned FILL_BITS       = 3;
	localparam int unsigned COUNT_BITS      = 3;
	localparam int unsigned IDX_BITS        = 2;
	localparam int unsigned STREAM_BITS     = VALUE_BITS + BYTE_BITS;

	localparam logic [WIDTH_BITS-1:0] RESET_WIDTH = WIDTH_BITS'(8);
	localparam logic [WIDTH_BITS-1:0] WIDTH_CAP   =
		WIDTH_BITS'((MAX_FIELD_WIDTH < VALUE_BITS) ? MAX_FIELD_WIDTH : VALUE_BITS);

	typedef enum logic {
		ACT_BIT   = 1'b0,
		ACT_FIELD = 1'b1
	} action_t;

	typedef logic [BYTE_BITS-1:0] byte_t;

	// Outcome of packing one item against the open byte
	typedef struct packed {
		byte_t [MAX_BYTES-1:0]   bytes;
		logic [COUNT_BITS-1:0]   nbytes;
		logic [FILL_BITS-1:0]    new_fill;
		byte_t                   new_pending;
	} pack_res_t;

endpackage

// ===== design/msbp_in_if.sv =====
// Input item channel: action and value.
interface msbp_in_if import msbp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

// ===== design/msbp_out_if.sv =====
// Output byte channel: packed byte and end-of-run mark.
interface msbp_out_if import msbp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [BYTE_BITS-1:0] out_byte;
	logic                 last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== design/msbp_cfg_if.sv =====
// Configuration write channel: field width.
interface msbp_cfg_if import msbp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [WIDTH_BITS-1:0] field_width;

	modport source (output valid, output field_width, input ready);
	modport sink   (input valid, input field_width, output ready);
endinterface

// ===== design/msbp_pack.sv =====
// Combinational packing of one item into the open byte.
module msbp_pack import msbp_pkg::*; (
	input  logic                  action,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [WIDTH_BITS-1:0] field_width,
	input  logic [FILL_BITS-1:0]  fill,
	input  byte_t                 pending,
	output pack_res_t             res
);

	logic [WIDTH_BITS-1:0]  width;
	logic [WIDTH_BITS-1:0]  total;
	logic [VALUE_BITS-1:0]  aligned;
	logic [STREAM_BITS-1:0] stream;

	always_comb begin
		if (action == ACT_BIT) begin
			width = WIDTH_BITS'(1);
		end else if (field_width > WIDTH_CAP) begin
			width = WIDTH_CAP;
		end else begin
			width = field_width;
		end
	end

	// left-justify the field; bits above the width fall off the top
	assign aligned = (action == ACT_BIT) ? {value[0], {(VALUE_BITS-1){1'b0}}}
		: (value << (WIDTH_BITS'(VALUE_BITS) - width));

	assign stream = {pending, {VALUE_BITS{1'b0}}}
		| ({aligned, {BYTE_BITS{1'b0}}} >> fill);

	assign total = WIDTH_BITS'(fill) + width;

	always_comb begin
		for (int k = 0; k < MAX_BYTES; k++) begin
			res.bytes[k] = stream[STREAM_BITS-1-BYTE_BITS*k -: BYTE_BITS];
		end
		res.nbytes   = total[WIDTH_BITS-1:FILL_BITS];
		res.new_fill = total[FILL_BITS-1:0];
		case (res.nbytes)
			3'd0:    res.new_pending = stream[39:32];
			3'd1:    res.new_pending = stream[31:24];
			3'd2:    res.new_pending = stream[23:16];
			3'd3:    res.new_pending = stream[15:8];
			3'd4:    res.new_pending = stream[7:0];
			default: res.new_pending = '0;
		endcase
	end

endmodule

// ===== design/msb_first_bit_packer.sv =====
// MSB-first bit packer: input register, packing logic, byte output buffer.
// An item waits in the input register until the byte buffer is free, then moves its bytes there.
// Throughput: one item per cycle while each completes at most one byte and the output is ready;
// an item completing more holds the buffer until its last byte is taken, one byte per transfer.
// Reset: field width 8, open byte empty, both stages empty.
module msb_first_bit_packer import msbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	msbp_in_if.sink    in_ch,
	msbp_out_if.source out_ch,
	msbp_cfg_if.sink   cfg_ch
);

	logic [WIDTH_BITS-1:0] field_width_q;
	logic [FILL_BITS-1:0]  fill_q;
	byte_t                 pending_q;

	logic                  valid_s1;
	logic                  action_s1;
	logic [VALUE_BITS-1:0] value_s1;

	logic                  valid_s2;
	byte_t [MAX_BYTES-1:0] bytes_s2;
	logic [IDX_BITS-1:0]   last_idx_s2;
	logic [IDX_BITS-1:0]   rd_idx_q;

	pack_res_t res;
	logic      out_xfer;
	logic      is_last;
	logic      s2_free;
	logic      s1_move;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_width_q <= RESET_WIDTH;
		end else if (cfg_ch.valid) begin
			field_width_q <= cfg_ch.field_width;
		end
	end

	msbp_pack u_pack (
		.action      (action_s1),
		.value       (value_s1),
		.field_width (field_width_q),
		.fill        (fill_q),
		.pending     (pending_q),
		.res         (res)
	);

	assign is_last  = (rd_idx_q == last_idx_s2);
	assign out_xfer = valid_s2 && out_ch.ready;
	assign s2_free  = !valid_s2 || (out_xfer && is_last);
	assign s1_move  = valid_s1 && s2_free;
	assign in_ch.ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			action_s1 <= in_ch.action;
			value_s1  <= in_ch.value;
		end
	end

	// open byte advances as the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			pending_q <= '0;
		end else if (s1_move) begin
			fill_q    <= res.new_fill;
			pending_q <= res.new_pending;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			rd_idx_q <= '0;
		end else if (s2_free) begin
			valid_s2 <= s1_move && (res.nbytes != '0);
			rd_idx_q <= '0;
		end else if (out_xfer) begin
			rd_idx_q <= rd_idx_q + IDX_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			bytes_s2    <= res.bytes;
			last_idx_s2 <= IDX_BITS'(res.nbytes - COUNT_BITS'(1));
		end
	end

	assign out_ch.valid       = valid_s2;
	assign out_ch.out_byte    = bytes_s2[rd_idx_q];
	assign out_ch.last_of_run = is_last;

endmodule
